[rtl/lrupr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement package
// Field widths and the packed result type shared by the page table logic.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int unsigned PAGE_NUM_W  = 16;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (2 + PAGE_NUM_W + 2 * COUNT_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [OUT_PAD_W-1:0]  pad;
    logic [COUNT_W-1:0]    fault_total;
    logic [COUNT_W-1:0]    hit_total;
    logic [PAGE_NUM_W-1:0] victim_page;
    logic                  evicted;
    logic                  hit;
  } result_t;

endpackage
`default_nettype wire

[rtl/lru_page_table_replacement_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page table replacement unit
// Fully associative page table with true least recently used replacement,
// reporting hit, eviction, victim page and saturating hit and fault totals.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata fields (lowest bit first)
//  --------+-----------+--------------------------------------------------------
//  in_     | slave     | page_number[15:0]
//  out_    | master    | hit[0] evicted[1] victim_page[17:2] hit_total[49:18]
//          |           | fault_total[81:50], zero pad [87:82]
//
//  One request per clock sustained while out_tready stays high; each taken
//  request sits in the input register while the parallel tag compare and
//  rank update settle, and its result is written into the result register
//  as soon as that register is empty or draining.
//  Reset (rst_n low, synchronous) empties the table and clears both totals.
//  A stall on out_tready holds the result register; the input register then
//  still takes one more request and holds it until the result drains.
//
module lru_page_table_replacement_unit #(
  parameter int unsigned TABLE_ENTRIES = 5,
  parameter int unsigned PAGE_WIDTH    = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // page_number[15:0]
  input  wire logic [lrupr_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // hit, evicted, victim_page[15:0], hit_total[31:0], fault_total[31:0], pad
  output logic [lrupr_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready
);

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam logic [RANK_W-1:0] RANK_LRU = RANK_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  FILL_MAX = CNT_W'(TABLE_ENTRIES);

  // Input register
  logic                                 in_valid_r;
  logic [lrupr_pkg::PAGE_NUM_W-1:0]     in_page_r;

  // Table state: tags and ranks are only read below the fill count
  logic [PAGE_WIDTH-1:0]                tags_r [TABLE_ENTRIES];
  logic [RANK_W-1:0]                    rank_r [TABLE_ENTRIES];
  logic [CNT_W-1:0]                     fill_r;
  logic [lrupr_pkg::COUNT_W-1:0]        hits_r;
  logic [lrupr_pkg::COUNT_W-1:0]        faults_r;

  // Result register
  logic                                 out_valid_r;
  lrupr_pkg::result_t                   res_r;

  // Pass logic
  logic                                 out_free;
  logic                                 adv;
  logic [PAGE_WIDTH-1:0]                tag;
  logic [TABLE_ENTRIES-1:0]             slot_vld;
  logic [TABLE_ENTRIES-1:0]             match;
  logic [TABLE_ENTRIES-1:0]             lru_vec;
  logic [TABLE_ENTRIES-1:0]             age;
  logic [IDX_W-1:0]                     hit_idx;
  logic [IDX_W-1:0]                     vic_idx;
  logic [IDX_W-1:0]                     slot;
  logic                                 found;
  logic                                 full;
  logic                                 age_all;
  logic [RANK_W-1:0]                    lim;
  logic [lrupr_pkg::COUNT_W-1:0]        page_ext;
  lrupr_pkg::result_t                   res_nxt;

  // Handshake: advance when the result register is empty or draining
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_page_r <= in_tdata[lrupr_pkg::PAGE_NUM_W-1:0];
    end
  end

  // Tag compare, victim pick, rank ageing and next result with totals
  always_comb begin
    page_ext = lrupr_pkg::COUNT_W'(in_page_r);
    tag      = page_ext[PAGE_WIDTH-1:0];
    full     = (fill_r == FILL_MAX);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_vld[i] = (CNT_W'(i) < fill_r);
      match[i]    = slot_vld[i] && (tags_r[i] == tag);
      lru_vec[i]  = (rank_r[i] == RANK_LRU);
    end
    found   = |match;
    hit_idx = '0;
    vic_idx = '0;
    // Walk downwards so the lowest-numbered slot wins
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (lru_vec[i]) begin
        vic_idx = IDX_W'(i);
      end
    end
    if (found) begin
      slot = hit_idx;
    end else if (full) begin
      slot = vic_idx;
    end else begin
      slot = fill_r[IDX_W-1:0];
    end
    age_all = !found && !full;
    lim     = found ? rank_r[hit_idx] : RANK_LRU;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      age[i] = slot_vld[i] && (age_all || (rank_r[i] < lim));
    end

    res_nxt             = '0;
    res_nxt.hit         = found;
    res_nxt.evicted     = !found && full;
    res_nxt.victim_page = res_nxt.evicted ?
                          lrupr_pkg::PAGE_NUM_W'(lrupr_pkg::COUNT_W'(tags_r[vic_idx])) :
                          '0;
    res_nxt.hit_total   = (found && hits_r != lrupr_pkg::COUNT_MAX) ? hits_r + 1'b1 : hits_r;
    res_nxt.fault_total = (!found && faults_r != lrupr_pkg::COUNT_MAX) ?
                          faults_r + 1'b1 : faults_r;
  end

  // Table update
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          rank_r[i] <= '0;
        end else if (age[i]) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
      if (!found) begin
        tags_r[slot] <= tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      hits_r   <= '0;
      faults_r <= '0;
    end else if (adv) begin
      if (!found && !full) begin
        fill_r <= fill_r + 1'b1;
      end
      hits_r   <= res_nxt.hit_total;
      faults_r <= res_nxt.fault_total;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count beyond table size");

  a_tags_unique: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |-> $onehot0(match))
    else $error("page held in more than one slot");

  a_lru_present: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> $onehot(lru_vec))
    else $error("full table without a single least recently used slot");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.evicted) |-> (full && !res_r.hit))
    else $error("eviction reported while table not full");

  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.evicted) |-> (res_r.victim_page == '0))
    else $error("victim page set without eviction");

endmodule
`default_nettype wire

[sim/lru_page_table_replacement_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page table replacement unit testbench
// Streams page references into the table under bursty input and a shifting
// output stall pattern. A local recency model predicts hit, eviction, victim
// page and both running totals for every request, and each result is checked
// field by field in arrival order.
// ----------------------------------------------------------------------------
module lru_page_table_replacement_unit_tb;

  localparam int unsigned TABLE_SLOTS  = 5;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef logic [lrupr_pkg::PAGE_NUM_W-1:0] page_t;
  typedef logic [lrupr_pkg::COUNT_W-1:0]    count_t;

  // Receiver stall modes, redrawn at random whenever stall_phase reaches a multiple of STALL_SPAN
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_SPARSE,
    STALL_LONG
  } stall_mode_t;
  localparam int unsigned STALL_SPAN = 80;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic [lrupr_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [lrupr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;

  lru_page_table_replacement_unit #(
    .TABLE_ENTRIES(TABLE_SLOTS),
    .PAGE_WIDTH   (lrupr_pkg::PAGE_NUM_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #1 clk = ~clk;
  end

  // Hold reset from the start, release it on a falling edge, never assert again
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Page table model: slot tags, recency ranks (0 = most recent), occupancy
  // and the two saturating totals, all as the block sees them after reset
  // --------------------------------------------------------------------------
  page_t                 slot_page [TABLE_SLOTS];
  int unsigned           slot_rank [TABLE_SLOTS];
  int unsigned           slots_used  = 0;
  count_t                hits_so_far   = '0;
  count_t                faults_so_far = '0;

  // Results predicted but not yet seen on out_, oldest first
  lrupr_pkg::result_t    expected_results [$];
  // Page references still to be offered on in_
  page_t                 pending_pages [$];

  int unsigned mismatches     = 0;
  int unsigned requests_taken = 0;
  int unsigned hits_seen      = 0;
  int unsigned evictions_seen = 0;
  logic        request_taken  = 1'b0;

  // Totals cannot reach saturation in a run of this length, but keep the clamp
  function automatic count_t bump_total(input count_t total);
    return (total == lrupr_pkg::COUNT_MAX) ? total : total + 1'b1;
  endfunction

  // Age every occupied slot whose rank sits below the given limit
  function automatic void age_slots(input int unsigned limit);
    for (int i = 0; i < slots_used; i++) begin
      if (slot_rank[i] < limit) slot_rank[i]++;
    end
  endfunction

  // Apply one page reference to the model and return the result it must give
  function automatic lrupr_pkg::result_t lookup_page(input page_t page);
    lrupr_pkg::result_t res;
    int                 found;
    int unsigned        oldest;
    res   = '0;
    found = -1;
    for (int i = 0; i < slots_used; i++) begin
      if (found < 0 && slot_page[i] == page) found = i;
    end
    if (found >= 0) begin
      // Hit: promote to most recent, age only the more recent entries
      res.hit     = 1'b1;
      hits_so_far = bump_total(hits_so_far);
      age_slots(slot_rank[found]);
      slot_rank[found] = 0;
    end else begin
      faults_so_far = bump_total(faults_so_far);
      if (slots_used < TABLE_SLOTS) begin
        // Fault with room: age everyone, fill the next free slot
        age_slots(32'hFFFF_FFFF);
        slot_page[slots_used] = page;
        slot_rank[slots_used] = 0;
        slots_used++;
      end else begin
        // Fault on a full table: evict the largest rank, lowest slot on a tie
        oldest = 0;
        for (int i = 1; i < TABLE_SLOTS; i++) begin
          if (slot_rank[i] > slot_rank[oldest]) oldest = i;
        end
        res.evicted     = 1'b1;
        res.victim_page = slot_page[oldest];
        age_slots(slot_rank[oldest]);
        slot_page[oldest] = page;
        slot_rank[oldest] = 0;
      end
    end
    res.hit_total   = hits_so_far;
    res.fault_total = faults_so_far;
    return res;
  endfunction

  task automatic check_field(input string name, input count_t want, input count_t got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: a directed opening, then working-set traffic with random content
  // --------------------------------------------------------------------------
  initial begin
    page_t       working_set [9];
    int unsigned set_size;
    int unsigned pick;
    page_t       page;

    // Fill from empty with the field extremes and a hit before the table is full
    pending_pages.push_back(16'h0000);
    pending_pages.push_back(16'hFFFF);
    pending_pages.push_back(16'h0000);
    pending_pages.push_back(16'h5555);
    pending_pages.push_back(16'hAAAA);
    pending_pages.push_back(16'h0001);
    // Full table: fault evicts the oldest page (0xFFFF)
    pending_pages.push_back(16'h8000);
    // Hit on the second oldest entry, then evict the oldest (0x0000)
    pending_pages.push_back(16'h5555);
    pending_pages.push_back(16'h1234);
    // Repeat the most recent page twice, then a page evicted earlier (0xFFFF)
    pending_pages.push_back(16'h1234);
    pending_pages.push_back(16'h1234);
    pending_pages.push_back(16'hFFFF);
    // Hits in shuffled order reorder the ranks; then faults walk the victims
    pending_pages.push_back(16'h0001);
    pending_pages.push_back(16'h8000);
    pending_pages.push_back(16'h5555);
    pending_pages.push_back(16'h7FFF);
    pending_pages.push_back(16'hFFFE);
    pending_pages.push_back(16'h0000);
    pending_pages.push_back(16'h8000);
    pending_pages.push_back(16'hAAAA);
    pending_pages.push_back(16'h0001);

    set_size = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Refresh the working set now and then; small sets fit, large ones thrash
      if (n % 40 == 0) begin
        set_size = $urandom_range(3, 9);
        for (int k = 0; k < 9; k++) working_set[k] = page_t'($urandom_range(0, 16'hFFFF));
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        page = working_set[$urandom_range(0, set_size - 1)];
      end else if (pick < 90) begin
        page = page_t'($urandom_range(0, 16'hFFFF));
      end else begin
        case ($urandom_range(0, 3))
          0:       page = 16'h0000;
          1:       page = 16'hFFFF;
          2:       page = 16'h0001 << $urandom_range(0, lrupr_pkg::PAGE_NUM_W - 1);
          default: page = ~(16'h0001 << $urandom_range(0, lrupr_pkg::PAGE_NUM_W - 1));
        endcase
      end
      pending_pages.push_back(page);
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps, valid held
  // steady until the request is taken
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    logic  next_valid;
    page_t next_data;
    next_valid = in_tvalid;
    next_data  = in_tdata;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      // Drop the request that went in on the last rising edge
      if (request_taken) begin
        request_taken = 1'b0;
        void'(pending_pages.pop_front());
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pages.size() > 0) begin
          next_valid = 1'b1;
          next_data  = pending_pages[0];
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
    in_tvalid <= next_valid;
    in_tdata  <= next_data;
  end

  // --------------------------------------------------------------------------
  // Result receiver: out_tready follows a stall mode that changes over time
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode  = STALL_NONE;
  int unsigned stall_phase = 0;

  always @(negedge clk) begin
    logic next_ready;
    stall_phase++;
    if (stall_phase % STALL_SPAN == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:   next_ready = 1'b1;
      STALL_RANDOM: next_ready = 1'($urandom_range(0, 1));
      STALL_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
      default:      next_ready = (stall_phase % 16 >= 12);
    endcase
    out_tready <= next_ready;
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result against the oldest prediction, then predict
  // for any request taken on this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lrupr_pkg::result_t got;
    lrupr_pkg::result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: 0x%0h", out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit",         count_t'(want.hit),         count_t'(got.hit));
          check_field("evicted",     count_t'(want.evicted),     count_t'(got.evicted));
          check_field("victim_page", count_t'(want.victim_page), count_t'(got.victim_page));
          check_field("hit_total",   want.hit_total,             got.hit_total);
          check_field("fault_total", want.fault_total,           got.fault_total);
          if (want.hit)     hits_seen++;
          if (want.evicted) evictions_seen++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(lookup_page(in_tdata));
        request_taken = 1'b1;
        requests_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // End of run: drain, allow for late stray results, then report
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_n);
    while (pending_pages.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end
    $display("Covered %0d page references: %0d hits, %0d faults, %0d evictions.",
             requests_taken, hits_seen, requests_taken - hits_seen, evictions_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #400000;
    $display("Timed out with %0d requests pending and %0d results outstanding.",
             pending_pages.size(), expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
